// ===== rtl/pfcphd_pkg.sv =====
// ----------------------------------------------------------------------------
// PFCP header deframer package
// Result record, event codes, parser modes and header constants.
// ----------------------------------------------------------------------------
package pfcphd_pkg;

    // Event codes carried in event_res.
    localparam logic [2:0] EV_PAYLOAD  = 3'd0;
    localparam logic [2:0] EV_HEADER   = 3'd1;
    localparam logic [2:0] EV_SHORT    = 3'd2;
    localparam logic [2:0] EV_LEN_DATA = 3'd3;
    localparam logic [2:0] EV_PRIO     = 3'd4;
    localparam logic [2:0] EV_LEN_HDR  = 3'd5;

    // Header geometry, in bytes.
    localparam logic [3:0]  LAST_POS_SHORT = 4'd7;
    localparam logic [3:0]  LAST_POS_SEID  = 4'd15;
    localparam logic [3:0]  SEQ_POS_SHORT  = 4'd4;
    localparam logic [3:0]  SEQ_POS_SEID   = 4'd12;
    localparam logic [3:0]  SEID_POS_FIRST = 4'd4;
    localparam logic [3:0]  SEID_POS_LAST  = 4'd11;
    localparam logic [15:0] EXTRA_SHORT    = 16'd4;
    localparam logic [15:0] EXTRA_SEID     = 16'd12;

    typedef enum logic [2:0] {
        MODE_HEADER  = 3'b001,
        MODE_PAYLOAD = 3'b010,
        MODE_DROP    = 3'b100
    } t_mode;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [2:0]  version;
        logic [7:0]  msg_code;
        logic        rsp_flag;
        logic        seid_flag;
        logic [63:0] session_id;
        logic [23:0] sequence_number;
        logic        prio_flag;
        logic [3:0]  priority_res;
        logic [15:0] payload_length;
        logic        more_flag;
    } t_result;

    function automatic logic code_is_reply(input logic [7:0] code);
        logic rsp;
        case (code)
            8'd2, 8'd4, 8'd6, 8'd8, 8'd10, 8'd11, 8'd13, 8'd15,
            8'd51, 8'd53, 8'd55, 8'd57: rsp = 1'b1;
            default: rsp = 1'b0;
        endcase
        return rsp;
    endfunction

    // A result that carries only an event code and a byte; all else is zero.
    function automatic t_result simple_result(input logic [2:0] ev,
                                              input logic [7:0] data);
        t_result res;
        res              = '0;
        res.event_res    = ev;
        res.payload_byte = data;
        return res;
    endfunction

endpackage

// ===== rtl/pfcphd_parser.sv =====
// ----------------------------------------------------------------------------
// PFCP header deframer: byte parser
// Holds the header/payload/drop state and turns one byte into up to two
// results. The second result, when present, is always a length error.
// ----------------------------------------------------------------------------
module pfcphd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output logic [1:0]          o_count,
    output pfcphd_pkg::t_result o_first
);
    import pfcphd_pkg::*;

    t_mode       r_mode, n_mode;
    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_flag, n_flag;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [63:0] r_seid, n_seid;
    logic [23:0] r_seq, n_seq;
    logic [15:0] r_rem, n_rem;

    logic [7:0]  flag_cur;
    logic        s_flag;
    logic        mp_flag;
    logic [3:0]  last_pos;
    logic [3:0]  seq_pos;
    logic [15:0] extra;
    logic [15:0] rem_dec;
    logic [15:0] body_len;

    always_comb begin
        flag_cur = (r_pos == 4'd0) ? i_byte : r_flag;
        s_flag   = flag_cur[0];
        mp_flag  = flag_cur[1];
        last_pos = s_flag ? LAST_POS_SEID : LAST_POS_SHORT;
        seq_pos  = s_flag ? SEQ_POS_SEID : SEQ_POS_SHORT;
        extra    = s_flag ? EXTRA_SEID : EXTRA_SHORT;
        rem_dec  = r_rem - 16'd1;
        body_len = r_len - extra;
    end

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_flag  = r_flag;
        n_type  = r_type;
        n_len   = r_len;
        n_seid  = r_seid;
        n_seq   = r_seq;
        n_rem   = r_rem;
        o_count = 2'd0;
        o_first = simple_result(EV_PAYLOAD, 8'd0);

        case (r_mode)
            MODE_DROP: begin
                if (i_last) begin
                    n_mode = MODE_HEADER;
                end
            end
            MODE_PAYLOAD: begin
                o_count = 2'd1;
                o_first = simple_result(EV_PAYLOAD, i_byte);
                n_rem   = rem_dec;
                if (rem_dec == 16'd0) begin
                    n_mode = MODE_HEADER;
                end else if (i_last) begin
                    o_count = 2'd2;
                    n_rem   = 16'd0;
                    n_mode  = MODE_HEADER;
                end
            end
            MODE_HEADER: begin
                if (r_pos == 4'd0) begin
                    n_flag = i_byte;
                    n_seid = '0;
                    n_seq  = '0;
                end
                if (r_pos == 4'd1) begin
                    n_type = i_byte;
                end else if (r_pos == 4'd2 || r_pos == 4'd3) begin
                    n_len = {r_len[7:0], i_byte};
                end else if (s_flag && r_pos >= SEID_POS_FIRST && r_pos <= SEID_POS_LAST) begin
                    n_seid = {r_seid[55:0], i_byte};
                end else if (r_pos >= seq_pos && r_pos <= seq_pos + 4'd2) begin
                    n_seq = {r_seq[15:0], i_byte};
                end

                if (r_pos != last_pos) begin
                    if (i_last) begin
                        o_count = 2'd1;
                        o_first = simple_result(EV_SHORT, 8'd0);
                        n_pos   = 4'd0;
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end else begin
                    n_pos = 4'd0;
                    // The length check takes precedence over the priority check.
                    if (r_len < extra || (mp_flag && !s_flag)) begin
                        o_count = 2'd1;
                        o_first = simple_result((r_len < extra) ? EV_LEN_HDR : EV_PRIO,
                                                8'd0);
                        n_mode  = i_last ? MODE_HEADER : MODE_DROP;
                    end else begin
                        o_count                 = 2'd1;
                        o_first                 = '0;
                        o_first.event_res       = EV_HEADER;
                        o_first.version         = r_flag[7:5];
                        o_first.msg_code        = r_type;
                        o_first.rsp_flag        = code_is_reply(r_type);
                        o_first.seid_flag       = s_flag;
                        o_first.session_id      = s_flag ? r_seid : 64'd0;
                        o_first.sequence_number = r_seq;
                        o_first.prio_flag       = mp_flag;
                        o_first.priority_res    = (s_flag && mp_flag) ? i_byte[3:0] : 4'd0;
                        o_first.payload_length  = body_len;
                        o_first.more_flag       = r_flag[2];
                        n_rem                   = body_len;
                        if (body_len == 16'd0) begin
                            n_mode = MODE_HEADER;
                        end else if (i_last) begin
                            o_count = 2'd2;
                            n_rem   = 16'd0;
                            n_mode  = MODE_HEADER;
                        end else begin
                            n_mode = MODE_PAYLOAD;
                        end
                    end
                end
            end
            default: begin
                n_mode = MODE_HEADER;
                n_pos  = 4'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEADER;
            r_pos  <= '0;
            r_flag <= '0;
            r_type <= '0;
            r_len  <= '0;
            r_seid <= '0;
            r_seq  <= '0;
            r_rem  <= '0;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_flag <= n_flag;
            r_type <= n_type;
            r_len  <= n_len;
            r_seid <= n_seid;
            r_seq  <= n_seq;
            r_rem  <= n_rem;
        end
    end

endmodule

// ===== rtl/pfcphd_out.sv =====
// ----------------------------------------------------------------------------
// PFCP header deframer: result register
// One result register plus a flag for the trailing length error that a
// byte may owe after its first result.
// ----------------------------------------------------------------------------
module pfcphd_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [1:0]          i_count,
    input  pfcphd_pkg::t_result i_first,
    input  logic                i_ready,
    output logic                o_slot_free,
    output logic                o_valid,
    output pfcphd_pkg::t_result o_result
);
    import pfcphd_pkg::*;

    logic    r_valid;
    logic    r_pend;
    t_result r_result;
    logic    take;

    assign take        = r_valid && i_ready;
    // The slot is free when empty, or when the current beat leaves with nothing owed.
    assign o_slot_free = !r_valid || (i_ready && !r_pend);
    assign o_valid     = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (take && r_pend) begin
            r_pend <= 1'b0;
        end else if (i_load && i_count != 2'd0) begin
            r_valid <= 1'b1;
            r_pend  <= (i_count == 2'd2);
        end else if (take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_pend) begin
            r_result <= simple_result(EV_LEN_DATA, 8'd0);
        end else if (i_load && i_count != 2'd0) begin
            r_result <= i_first;
        end
    end

endmodule

// ===== rtl/pfcp_header_deframer.sv =====
// ----------------------------------------------------------------------------
// PFCP header deframer
// Splits a byte stream of bundled PFCP messages into header and payload beats.
// ----------------------------------------------------------------------------
// Bytes enter through a one-beat input register and are parsed combinationally
// into a one-beat result register, so the block takes one byte per cycle
// while the output keeps up. A byte yields no beat (a header byte before the
// last, or dropped after an error), one beat (header, payload byte or error),
// or two beats when a buffer ends inside a declared payload: the byte or
// header is followed by a "length exceeds data" beat. Header fields appear
// on the header beat once the last header byte (8th, or 16th with SEID)
// arrives; all fields other than the event and payload byte are zero on
// non-header beats.
module pfcp_header_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_version,
    output logic [7:0]  o_msg_code,
    output logic        o_rsp_flag,
    output logic        o_seid_flag,
    output logic [63:0] o_session_id,
    output logic [23:0] o_sequence_number,
    output logic        o_prio_flag,
    output logic [3:0]  o_priority_res,
    output logic [15:0] o_payload_length,
    output logic        o_more_flag
);
    import pfcphd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       advance;
    logic       slot_free;
    logic [1:0] count;
    t_result    first;
    t_result    result;

    // A byte that produces nothing may retire even while the output stalls.
    assign advance = r_in_valid && (count == 2'd0 || slot_free);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_buffer_end;
        end
    end

    pfcphd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_count   (count),
        .o_first   (first)
    );

    pfcphd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_count     (count),
        .i_first     (first),
        .i_ready     (i_ready),
        .o_slot_free (slot_free),
        .o_valid     (o_valid),
        .o_result    (result)
    );

    assign o_event_res       = result.event_res;
    assign o_payload_byte    = result.payload_byte;
    assign o_version         = result.version;
    assign o_msg_code        = result.msg_code;
    assign o_rsp_flag        = result.rsp_flag;
    assign o_seid_flag       = result.seid_flag;
    assign o_session_id      = result.session_id;
    assign o_sequence_number = result.sequence_number;
    assign o_prio_flag       = result.prio_flag;
    assign o_priority_res    = result.priority_res;
    assign o_payload_length  = result.payload_length;
    assign o_more_flag       = result.more_flag;

endmodule
